@@ hw/rtl/cidf_pkg.sv @@
package cidf_pkg;

    localparam int OP_W     = 3;
    localparam int PROC_W   = 22;
    localparam int CHAN_W   = 16;
    localparam int BUS_W    = 8;
    localparam int ID_W     = 16;
    localparam int STATUS_W = 3;
    localparam int SIDX_W   = 4;
    localparam int NODE_W   = 8;

    // A route request reports at most this many matching slots.
    localparam int RESULT_CAP = 16;

    typedef enum logic [OP_W-1:0] {
        OP_ADD_CONN  = 3'd0,
        OP_DEL_CONN  = 3'd1,
        OP_ADD_ID    = 3'd2,
        OP_DEL_ID    = 3'd3,
        OP_ROUTE     = 3'd4
    } op_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK          = 3'd0,
        ST_NOT_FOUND   = 3'd1,
        ST_FULL        = 3'd2,
        ST_BAD_BUS     = 3'd3,
        ST_BAD_KEY     = 3'd4,
        ST_FILTER_FULL = 3'd5
    } status_t;

    // Decoded command kind handed from the front end to the table engine.
    typedef enum logic [2:0] {
        K_ERR,
        K_ADD,
        K_DEL,
        K_ADDF,
        K_DELF,
        K_ROUTE
    } kind_t;

    typedef struct packed {
        kind_t             kind;
        logic [PROC_W-1:0] proc;
        logic [CHAN_W-1:0] chan;
        logic              bus_ok;
        logic [ID_W-1:0]   id;
    } cmd_t;

    typedef enum logic [2:0] {
        B_IDLE,
        B_EXEC,
        B_FMOD,
        B_SCAN,
        B_RFIN
    } bstate_t;

endpackage

@@ hw/rtl/cidf_in_if.sv @@
interface cidf_in_if
    import cidf_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [OP_W-1:0]   operation;
    logic [PROC_W-1:0] process_number;
    logic [CHAN_W-1:0] channel_number;
    logic [BUS_W-1:0]  bus_number;
    logic [ID_W-1:0]   message_id;

    modport source (
        output valid, operation, process_number, channel_number, bus_number, message_id,
        input  ready
    );
    modport sink (
        input  valid, operation, process_number, channel_number, bus_number, message_id,
        output ready
    );
endinterface

@@ hw/rtl/cidf_out_if.sv @@
interface cidf_out_if
    import cidf_pkg::*;
();
    logic                valid;
    logic                ready;
    logic [STATUS_W-1:0] status;
    logic [SIDX_W-1:0]   slot_index;
    logic [NODE_W-1:0]   node_id;
    logic                last;

    modport source (
        output valid, status, slot_index, node_id, last,
        input  ready
    );
    modport sink (
        input  valid, status, slot_index, node_id, last,
        output ready
    );
endinterface

@@ hw/rtl/cidf_front.sv @@
module cidf_front
    import cidf_pkg::*;
#(
    parameter int BUS_PORTS = 4
) (
    input  logic   clk,
    input  logic   rst_n,
    cidf_in_if.sink in_ch,
    output logic   cmd_valid,
    output cmd_t   cmd,
    input  logic   cmd_pop
);

    cmd_t       q_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] cnt_reg, cnt_next;
    cmd_t       dec;
    logic       push;
    logic       bad_key;

    // Classify the request; a malformed request reaches the engine as K_ERR.
    always_comb
    begin
        bad_key    = (in_ch.process_number == '0) || (in_ch.channel_number == '0);
        dec.proc   = in_ch.process_number;
        dec.chan   = in_ch.channel_number;
        dec.id     = in_ch.message_id;
        dec.bus_ok = (32'(in_ch.bus_number) < 32'(BUS_PORTS));
        dec.kind   = K_ERR;
        case (op_t'(in_ch.operation))
            OP_ADD_CONN: dec.kind = bad_key ? K_ERR : K_ADD;
            OP_DEL_CONN: dec.kind = bad_key ? K_ERR : K_DEL;
            OP_ADD_ID:   dec.kind = (bad_key || in_ch.message_id == '0) ? K_ERR : K_ADDF;
            OP_DEL_ID:   dec.kind = (bad_key || in_ch.message_id == '0) ? K_ERR : K_DELF;
            OP_ROUTE:    dec.kind = (in_ch.message_id == '0) ? K_ERR : K_ROUTE;
            default:     dec.kind = K_ERR;
        endcase
    end

    assign in_ch.ready = (cnt_reg != 2'd2);
    assign push        = in_ch.valid && in_ch.ready;
    assign cmd_valid   = (cnt_reg != 2'd0);
    assign cmd         = q_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = cmd_pop ? ~rd_ptr_reg : rd_ptr_reg;
        cnt_next    = cnt_reg + 2'(push) - 2'(cmd_pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_reg[wr_ptr_reg] <= dec;
        end
    end

endmodule

@@ hw/rtl/cidf_back.sv @@
module cidf_back
    import cidf_pkg::*;
#(
    parameter int CONN_SLOTS       = 16,
    parameter int FILTERS_PER_CONN = 16
) (
    input  logic      clk,
    input  logic      rst_n,
    input  logic      cmd_valid,
    input  cmd_t      cmd,
    output logic      cmd_pop,
    cidf_out_if.source out_ch
);

    localparam int SLOT_W = (CONN_SLOTS > 1) ? $clog2(CONN_SLOTS) : 1;
    localparam int SCAN_W = $clog2(CONN_SLOTS + 1);
    localparam int ROW_W  = FILTERS_PER_CONN * ID_W;
    localparam int FIDX_W = (FILTERS_PER_CONN > 1) ? $clog2(FILTERS_PER_CONN) : 1;
    localparam int HIT_W  = $clog2(RESULT_CAP + 1);

    bstate_t state_reg, state_next;
    cmd_t    cmd_reg, cmd_next;

    logic [CONN_SLOTS-1:0] live_reg;
    logic [CONN_SLOTS-1:0] row_valid_reg;
    logic [PROC_W-1:0]     proc_reg [CONN_SLOTS];
    logic [CHAN_W-1:0]     chan_reg [CONN_SLOTS];

    logic [ROW_W-1:0] mem [CONN_SLOTS];
    logic [ROW_W-1:0] rdata_reg;
    logic             rvalid_reg;

    logic [SLOT_W-1:0] fslot_reg, fslot_next;
    logic [SCAN_W-1:0] issue_reg, issue_next;
    logic              rd_vld_reg, rd_vld_next;
    logic [SLOT_W-1:0] rd_slot_reg, rd_slot_next;
    logic              pend_reg, pend_next;
    logic [SLOT_W-1:0] pend_slot_reg, pend_slot_next;
    logic [HIT_W-1:0]  hits_reg, hits_next;

    logic                out_valid_reg;
    logic [STATUS_W-1:0] out_status_reg;
    logic [SIDX_W-1:0]   out_slot_reg;
    logic [NODE_W-1:0]   out_node_reg;
    logic                out_last_reg;

    logic                out_free;
    logic                emit;
    status_t             e_status;
    logic [SLOT_W-1:0]   e_slot;
    logic [NODE_W-1:0]   e_node;
    logic                e_last;

    logic              slot_set, slot_clr;
    logic [SLOT_W-1:0] slot_addr;
    logic              mem_wr;
    logic [ROW_W-1:0]  mem_wdata;
    logic              rd_en;
    logic [SLOT_W-1:0] rd_addr;

    logic              key_hit, free_hit;
    logic [SLOT_W-1:0] key_idx, free_idx;
    logic [ROW_W-1:0]  row;
    logic              row_hit, zero_hit, eq_hit;
    logic [FIDX_W-1:0] zero_idx, eq_idx;
    logic              scan_hit, scan_block, scan_cap;

    assign out_free = !out_valid_reg || out_ch.ready;

    // Key lookup and free-slot search compare all slots at once; lowest wins.
    always_comb
    begin
        key_hit  = 1'b0;
        key_idx  = '0;
        free_hit = 1'b0;
        free_idx = '0;
        for (int s = CONN_SLOTS - 1; s >= 0; s--)
        begin
            if (live_reg[s] && proc_reg[s] == cmd_reg.proc && chan_reg[s] == cmd_reg.chan)
            begin
                key_hit = 1'b1;
                key_idx = SLOT_W'(s);
            end
            if (!live_reg[s])
            begin
                free_hit = 1'b1;
                free_idx = SLOT_W'(s);
            end
        end
    end

    // A row that was never written since its slot was cleared reads as all zero.
    always_comb
    begin
        row      = rvalid_reg ? rdata_reg : '0;
        row_hit  = 1'b0;
        zero_hit = 1'b0;
        zero_idx = '0;
        eq_hit   = 1'b0;
        eq_idx   = '0;
        for (int f = FILTERS_PER_CONN - 1; f >= 0; f--)
        begin
            if (row[f*ID_W +: ID_W] == cmd_reg.id)
            begin
                row_hit = 1'b1;
                eq_hit  = 1'b1;
                eq_idx  = FIDX_W'(f);
            end
            if (row[f*ID_W +: ID_W] == '0)
            begin
                zero_hit = 1'b1;
                zero_idx = FIDX_W'(f);
            end
        end
    end

    assign scan_hit   = rd_vld_reg && live_reg[rd_slot_reg] && row_hit;
    assign scan_block = scan_hit && pend_reg && !out_free;
    assign scan_cap   = scan_hit && (hits_reg == HIT_W'(RESULT_CAP - 1));

    // Next-state logic.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            B_IDLE:
            begin
                if (cmd_valid)
                begin
                    state_next = (cmd.kind == K_ROUTE) ? B_SCAN : B_EXEC;
                end
            end
            B_EXEC:
            begin
                if ((cmd_reg.kind == K_ADDF || cmd_reg.kind == K_DELF) && key_hit)
                begin
                    state_next = B_FMOD;
                end
                else if (out_free)
                begin
                    state_next = B_IDLE;
                end
            end
            B_FMOD:
            begin
                if (out_free)
                begin
                    state_next = B_IDLE;
                end
            end
            B_SCAN:
            begin
                if (!scan_block &&
                    (scan_cap || (issue_reg == SCAN_W'(CONN_SLOTS) && !rd_vld_reg)))
                begin
                    state_next = B_RFIN;
                end
            end
            B_RFIN:
            begin
                if (out_free)
                begin
                    state_next = B_IDLE;
                end
            end
            default: state_next = B_IDLE;
        endcase
    end

    // Datapath controls.
    always_comb
    begin
        cmd_pop        = 1'b0;
        cmd_next       = cmd_reg;
        emit           = 1'b0;
        e_status       = ST_OK;
        e_slot         = '0;
        e_node         = '0;
        e_last         = 1'b1;
        slot_set       = 1'b0;
        slot_clr       = 1'b0;
        slot_addr      = '0;
        mem_wr         = 1'b0;
        mem_wdata      = row;
        rd_en          = 1'b0;
        rd_addr        = '0;
        fslot_next     = fslot_reg;
        issue_next     = issue_reg;
        rd_vld_next    = rd_vld_reg;
        rd_slot_next   = rd_slot_reg;
        pend_next      = pend_reg;
        pend_slot_next = pend_slot_reg;
        hits_next      = hits_reg;
        case (state_reg)
            B_IDLE:
            begin
                if (cmd_valid)
                begin
                    cmd_pop     = 1'b1;
                    cmd_next    = cmd;
                    issue_next  = '0;
                    rd_vld_next = 1'b0;
                    pend_next   = 1'b0;
                    hits_next   = '0;
                end
            end
            B_EXEC:
            begin
                case (cmd_reg.kind)
                    K_ADD:
                    begin
                        emit = out_free;
                        if (!free_hit)
                        begin
                            e_status = ST_FULL;
                        end
                        else if (!cmd_reg.bus_ok)
                        begin
                            e_status = ST_BAD_BUS;
                        end
                        else
                        begin
                            e_slot    = free_idx;
                            slot_set  = out_free;
                            slot_addr = free_idx;
                        end
                    end
                    K_DEL:
                    begin
                        emit = out_free;
                        if (!key_hit)
                        begin
                            e_status = ST_NOT_FOUND;
                        end
                        else
                        begin
                            e_slot    = key_idx;
                            slot_clr  = out_free;
                            slot_addr = key_idx;
                        end
                    end
                    K_ADDF, K_DELF:
                    begin
                        if (key_hit)
                        begin
                            rd_en      = 1'b1;
                            rd_addr    = key_idx;
                            fslot_next = key_idx;
                        end
                        else
                        begin
                            emit     = out_free;
                            e_status = ST_NOT_FOUND;
                        end
                    end
                    default:
                    begin
                        emit     = out_free;
                        e_status = ST_BAD_KEY;
                    end
                endcase
            end
            B_FMOD:
            begin
                emit   = out_free;
                e_slot = fslot_reg;
                if (cmd_reg.kind == K_ADDF)
                begin
                    if (zero_hit)
                    begin
                        mem_wr = out_free;
                        mem_wdata[32'(zero_idx)*ID_W +: ID_W] = cmd_reg.id;
                    end
                    else
                    begin
                        e_status = ST_FILTER_FULL;
                    end
                end
                else
                begin
                    if (eq_hit)
                    begin
                        mem_wr = out_free;
                        mem_wdata[32'(eq_idx)*ID_W +: ID_W] = '0;
                    end
                    else
                    begin
                        e_status = ST_NOT_FOUND;
                    end
                end
            end
            B_SCAN:
            begin
                if (!scan_block)
                begin
                    if (scan_hit)
                    begin
                        emit           = pend_reg;
                        e_slot         = pend_slot_reg;
                        e_node         = chan_reg[pend_slot_reg][NODE_W-1:0];
                        e_last         = 1'b0;
                        pend_next      = 1'b1;
                        pend_slot_next = rd_slot_reg;
                        hits_next      = hits_reg + 1'b1;
                    end
                    if (!scan_cap && issue_reg != SCAN_W'(CONN_SLOTS))
                    begin
                        rd_en        = 1'b1;
                        rd_addr      = issue_reg[SLOT_W-1:0];
                        rd_vld_next  = 1'b1;
                        rd_slot_next = issue_reg[SLOT_W-1:0];
                        issue_next   = issue_reg + 1'b1;
                    end
                    else
                    begin
                        rd_vld_next = 1'b0;
                    end
                end
            end
            B_RFIN:
            begin
                emit = out_free;
                if (pend_reg)
                begin
                    e_slot = pend_slot_reg;
                    e_node = chan_reg[pend_slot_reg][NODE_W-1:0];
                end
                else
                begin
                    e_status = ST_NOT_FOUND;
                end
            end
            default:
            begin
                emit = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= B_IDLE;
            live_reg      <= '0;
            row_valid_reg <= '0;
            out_valid_reg <= 1'b0;
            rd_vld_reg    <= 1'b0;
            pend_reg      <= 1'b0;
            hits_reg      <= '0;
            issue_reg     <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            rd_vld_reg <= rd_vld_next;
            pend_reg   <= pend_next;
            hits_reg   <= hits_next;
            issue_reg  <= issue_next;
            if (slot_set)
            begin
                live_reg[slot_addr]      <= 1'b1;
                row_valid_reg[slot_addr] <= 1'b0;
            end
            if (slot_clr)
            begin
                live_reg[slot_addr]      <= 1'b0;
                row_valid_reg[slot_addr] <= 1'b0;
            end
            if (mem_wr)
            begin
                row_valid_reg[fslot_reg] <= 1'b1;
            end
            if (out_free)
            begin
                out_valid_reg <= emit;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg       <= cmd_next;
        fslot_reg     <= fslot_next;
        rd_slot_reg   <= rd_slot_next;
        pend_slot_reg <= pend_slot_next;
        if (slot_set)
        begin
            proc_reg[slot_addr] <= cmd_reg.proc;
            chan_reg[slot_addr] <= cmd_reg.chan;
        end
        if (out_free && emit)
        begin
            out_status_reg <= e_status;
            out_slot_reg   <= SIDX_W'(e_slot);
            out_node_reg   <= e_node;
            out_last_reg   <= e_last;
        end
    end

    // Filter store: one row of ids per slot, one read and one write port.
    always_ff @(posedge clk)
    begin
        if (mem_wr)
        begin
            mem[fslot_reg] <= mem_wdata;
        end
        if (rd_en)
        begin
            rdata_reg  <= mem[rd_addr];
            rvalid_reg <= row_valid_reg[rd_addr];
        end
    end

    assign out_ch.valid      = out_valid_reg;
    assign out_ch.status     = out_status_reg;
    assign out_ch.slot_index = out_slot_reg;
    assign out_ch.node_id    = out_node_reg;
    assign out_ch.last       = out_last_reg;

    a_err_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_status_reg != ST_OK) |-> out_last_reg)
        else $error("error result without last");

    a_node_only_ok: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_node_reg != '0) |-> (out_status_reg == ST_OK))
        else $error("node id on a failed result");

    a_hits_cap: assert property (@(posedge clk) disable iff (!rst_n)
        hits_reg <= HIT_W'(RESULT_CAP))
        else $error("route hit count above cap");

    a_no_write_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == B_SCAN) |-> (!mem_wr && !slot_set && !slot_clr))
        else $error("table written during route scan");

endmodule

@@ hw/rtl/connection_id_filter_table_top.sv @@
// Connection id filter table.
// Requests arrive on in_ch (valid/ready); one request is accepted at a clock
// edge where both are high. Each request adds or deletes a connection slot,
// adds or deletes a subscribed message id on a slot, or routes a message id.
// Results leave on out_ch (valid/ready); every request gives one result with
// last set, except a route, which gives one result per matching live slot in
// slot order (at most 16), the final one marked by last, or one not-found
// result when no live slot matches.
// A front end checks keys and ids and parks up to two decoded requests; the
// table engine behind it handles one request at a time. A filter request
// first reads the filter-store row of its slot, then updates the row. A route
// scans one slot per cycle, unless the result register is blocked, with all
// filters of the slot compared at once; each match is shown once the next
// match is found. The single read port of the filter store sets this scan rate.
// Reset empties every slot and marks every filter row unwritten at once, so
// the block accepts requests in the first cycle after reset.
// When the receiver holds ready low, the result register keeps its value, the
// engine waits once it has a result to give, and once the two-entry queue
// fills in_ch.ready drops.
module connection_id_filter_table_top
    import cidf_pkg::*;
#(
    parameter int CONN_SLOTS       = 16,
    parameter int FILTERS_PER_CONN = 16,
    parameter int BUS_PORTS        = 4
) (
    input  logic        clk,
    input  logic        rst_n,
    cidf_in_if.sink     in_ch,
    cidf_out_if.source  out_ch
);

    cmd_t cmd;
    logic cmd_valid;
    logic cmd_pop;

    // Request decode and the queue that decouples it from the engine.
    cidf_front #(
        .BUS_PORTS (BUS_PORTS)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_ch     (in_ch),
        .cmd_valid (cmd_valid),
        .cmd       (cmd),
        .cmd_pop   (cmd_pop)
    );

    // Slot table, filter store and route scan.
    cidf_back #(
        .CONN_SLOTS       (CONN_SLOTS),
        .FILTERS_PER_CONN (FILTERS_PER_CONN)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd       (cmd),
        .cmd_pop   (cmd_pop),
        .out_ch    (out_ch)
    );

endmodule
